// ----- rtl/core/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window max spread block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW_DEF = 1024;
  localparam int CFG_W          = 11;
  localparam int SAMPLE_W       = 32;

  typedef struct packed {
    logic accept;
    logic rd;
    logic cmp;
    logic load;
  } swm_cmd_t;

  typedef struct packed {
    logic will_fill;
    logic scan_last;
    logic out_free;
  } swm_sts_t;

endpackage

// ----- rtl/core/sliding_window_max_spread_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_max_spread_top
// Reports per sample the spread of the latest window and the best so far.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// cfg       in         cfg_data[10:0] window_length
// s_axis    in         tdata[31:0] sample, tlast last_sample
// m_axis    out        tdata[31:0] window_spread, [63:32] best_spread,
//                      tuser window_full, tlast sequence_done
//
// A sample whose window is not full skips the scan; otherwise the scan
// steps through the ring memory read port one entry at a time over the
// effective window length L, and no new sample is accepted until it ends.
// Reset is synchronous and clears all sequence state; the window length
// returns to 1. A stalled result waits in the output register while the
// next sample is accepted.
// ----------------------------------------------------------------------------
module sliding_window_max_spread_top
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,   // [31:0] window_spread, [63:32] best_spread
  output logic                m_tlast,
  output logic                m_tuser    // [0] window_full
);

  swm_cmd_t cmd;
  swm_sts_t sts;

  assign cfg_ready = 1'b1;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- rtl/core/swm_ctrl.sv -----
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: accepts a sample, steps the window scan, hands off the result.
// ----------------------------------------------------------------------------
module swm_ctrl
  import swm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  swm_sts_t sts,
  output swm_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = sts.will_fill ? ST_RD : ST_FIN;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = sts.scan_last ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/swm_datapath.sv -----
// ----------------------------------------------------------------------------
// swm_datapath
// Sample ring memory, window scan with min and max, best spread and result.
// ----------------------------------------------------------------------------
module swm_datapath
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [SAMPLE_W-1:0] s_tdata,
  input  logic                s_tlast,
  input  swm_cmd_t            cmd,
  output swm_sts_t            sts,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_WINDOW - 1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_WINDOW);

  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] rdata;
  logic [CFG_W-1:0]    window_length;
  logic [CW-1:0]       eff_len;
  logic [CW-1:0]       len;
  logic [CW-1:0]       fill_count;
  logic [CW-1:0]       fill_next;
  logic [AW-1:0]       write_position;
  logic [AW-1:0]       pos;
  logic [CW-1:0]       cnt;
  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W-1:0] lo;
  logic                full;
  logic                last;
  logic [31:0]         best;
  logic [31:0]         spread;
  logic [31:0]         best_next;
  logic                out_valid;
  logic [31:0]         out_spread;
  logic [31:0]         out_best;
  logic                out_full;
  logic                out_last;

  always_comb begin
    if (window_length == '0) begin
      eff_len = CW'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      eff_len = MAX_CNT;
    end else begin
      eff_len = CW'(window_length);
    end
    fill_next     = (fill_count < MAX_CNT) ? fill_count + CW'(1) : fill_count;
    spread        = full ? (hi - lo) : 32'd0;
    best_next     = (spread > best) ? spread : best;
    sts.will_fill = fill_next >= eff_len;
    sts.scan_last = (cnt + CW'(1)) == len;
    sts.out_free  = !out_valid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[write_position] <= s_tdata;
    end
    if (cmd.rd) begin
      rdata <= mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= CFG_W'(1);
      fill_count     <= '0;
      write_position <= '0;
      best           <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_length <= cfg_data;
      end
      if (cmd.accept) begin
        fill_count     <= fill_next;
        write_position <= (write_position == TOP_ADDR) ? '0 : write_position + AW'(1);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
        if (last) begin
          fill_count     <= '0;
          write_position <= '0;
          best           <= '0;
        end else begin
          best <= best_next;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hi   <= s_tdata;
      lo   <= s_tdata;
      last <= s_tlast;
      full <= sts.will_fill;
      len  <= eff_len;
      pos  <= write_position;
      cnt  <= '0;
    end
    if (cmd.cmp) begin
      if ($signed(hi) < $signed(rdata)) begin
        hi <= rdata;
      end
      if ($signed(rdata) < $signed(lo)) begin
        lo <= rdata;
      end
      pos <= (pos == '0) ? TOP_ADDR : pos - AW'(1);
      cnt <= cnt + CW'(1);
    end
    if (cmd.load) begin
      out_spread <= spread;
      out_best   <= best_next;
      out_full   <= full;
      out_last   <= last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_best, out_spread};
  assign m_tlast  = out_last;
  assign m_tuser  = out_full;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= MAX_CNT) else $error("fill count beyond window depth");
  a_empty_spread: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_full) |-> (out_spread == 32'd0))
    else $error("spread reported for a window that is not full");
  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_best >= out_spread)) else $error("best spread below window spread");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp |-> (cnt < len)) else $error("scan ran past window length");
`endif

endmodule

// ----- dv/tb_sliding_window_max_spread_top.sv -----
// ----------------------------------------------------------------------------
// tb_sliding_window_max_spread_top
// Drives sample sequences through several window lengths, predicts the window
// spread and the running best spread per sample, and checks every result.
// ----------------------------------------------------------------------------
module tb_sliding_window_max_spread_top;
  import swm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = MAX_WINDOW_DEF;
  localparam logic [CFG_W-1:0] WLEN_RESET = 11'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_item_t;

  typedef struct packed {
    logic        full;
    logic [31:0] spread;
    logic [31:0] best;
    logic        done;
  } spread_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  sliding_window_max_spread_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  sample_item_t   pending_samples[$];
  spread_result_t expected_spreads[$];

  logic signed [31:0] ring[MAXW];
  int unsigned fill_cnt = 0;
  int unsigned wr_pos = 0;
  logic [31:0] best_spread = '0;
  logic [CFG_W-1:0] wlen_reg = WLEN_RESET;

  int errors = 0;
  int results_seen = 0;
  int sequences_seen = 0;
  int full_seen = 0;
  bit sender_hold = 1'b0;

  function automatic spread_result_t predict_spread(sample_item_t it);
    spread_result_t r;
    int unsigned len;
    int unsigned pos;
    logic signed [31:0] hi, lo, v;
    len = (wlen_reg == 0) ? 1 : ((wlen_reg > MAXW) ? MAXW : wlen_reg);
    ring[wr_pos] = it.sample;
    wr_pos = (wr_pos + 1) % MAXW;
    if (fill_cnt < MAXW) fill_cnt++;
    r.full = (fill_cnt >= len);
    r.spread = '0;
    if (r.full) begin
      hi = it.sample;
      lo = it.sample;
      pos = wr_pos;
      for (int k = 0; k < len; k++) begin
        pos = (pos == 0) ? MAXW - 1 : pos - 1;
        v = ring[pos];
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
      r.spread = hi - lo;
      if (r.spread > best_spread) best_spread = r.spread;
    end
    r.best = best_spread;
    r.done = it.last;
    if (it.last) begin
      fill_cnt = 0;
      wr_pos = 0;
      best_spread = '0;
    end
    return r;
  endfunction

  // Driver.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_spreads.push_back(predict_spread({s_tdata, s_tlast}));
        void'(pending_samples.pop_front());
        send_gap <= $urandom_range(0, 4);
      end
      if (s_tvalid && s_tready) begin
        if (pending_samples.size() > 0 && !sender_hold && $urandom_range(0, 4) == 0
            && send_gap == 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_samples[0].sample;
          s_tlast <= pending_samples[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end else if (!s_tvalid) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_samples.size() > 0 && !sender_hold) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_samples[0].sample;
          s_tlast <= pending_samples[0].last;
        end
      end
    end
  end

  // Monitor and result-side stall.
  int recv_gap = 0;
  always @(posedge clk) begin
    spread_result_t got, exp_r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[31:0], m_tdata[63:32], m_tlast};
        results_seen++;
        if (got.full) full_seen++;
        if (got.done) sequences_seen++;
        if (expected_spreads.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result: %p", got);
        end else begin
          exp_r = expected_spreads.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch at result %0d: expected %p, actual %p",
                       results_seen, exp_r, got);
          end
        end
        recv_gap = $urandom_range(0, 4);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || s_tvalid || expected_spreads.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_wlen(logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    wlen_reg = value;
  endtask

  task automatic queue_sequence(int unsigned count, int unsigned mode);
    sample_item_t it;
    for (int i = 0; i < count; i++) begin
      case (mode)
        0: it.sample = $urandom;
        1: it.sample = $urandom_range(0, 15) - 8;
        default: it.sample = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      endcase
      it.last = (i == count - 1);
      pending_samples.push_back(it);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] wlens[8];
    sample_item_t it;
    int unsigned n;
    wlens = '{11'd0, 11'd2, 11'd5, 11'd1024, 11'd2047, 11'd3, 11'd1, 11'd16};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, single-sample sequence, default length of 1.
    it = '{32'h80000000, 1'b0}; pending_samples.push_back(it);
    it = '{32'h7fffffff, 1'b0}; pending_samples.push_back(it);
    it = '{32'h00000000, 1'b1}; pending_samples.push_back(it);
    it = '{32'hffffffff, 1'b1}; pending_samples.push_back(it);
    wait_drained();
    write_wlen(11'd3);
    it = '{32'h7fffffff, 1'b0}; pending_samples.push_back(it);
    it = '{32'h80000000, 1'b1}; pending_samples.push_back(it);
    queue_sequence(6, 2);
    queue_sequence(8, 1);
    // Length changed mid-sequence takes effect on the next sample.
    queue_sequence(3, 0);
    void'(pending_samples.pop_back());
    it = '{32'h12345678, 1'b0}; pending_samples.push_back(it);
    wait_drained();
    write_wlen(11'd2);
    it = '{32'h00000005, 1'b1}; pending_samples.push_back(it);
    wait_drained();

    sender_hold = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      if (wlens[ph] < 11'd1024) begin
        write_wlen(wlens[ph]);
        n = (wlens[ph] >= 11'd16) ? 1 : 2;
        for (int s = 0; s < n; s++) begin
          queue_sequence($urandom_range(1, 3 * wlens[ph] + 4), $urandom_range(0, 2));
        end
        if (ph == 2) begin
          // Hold the sender until every outstanding result has come back.
          repeat (30) @(posedge clk);
          sender_hold = 1'b1;
          while (s_tvalid || expected_spreads.size() > 0) @(posedge clk);
          sender_hold = 1'b0;
        end
        wait_drained();
      end
    end
    // One long sequence: an oversized length first so the ring fills and
    // wraps, then the largest legal length for the closing samples.
    write_wlen(11'd2047);
    queue_sequence(1025, 0);
    pending_samples[pending_samples.size() - 1].last = 1'b0;
    wait_drained();
    write_wlen(11'd1024);
    queue_sequence(2, 0);
    wait_drained();

    $display("Checked %0d results over %0d sequences, %0d with a full window.",
             results_seen, sequences_seen, full_seen);
    $display("Window lengths covered 0, 1, 2, 3, 5, 16, 1024 and 2047.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in total.", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Timeout.");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/swm_pkg.sv
rtl/core/swm_ctrl.sv
rtl/core/swm_datapath.sv
rtl/core/sliding_window_max_spread_top.sv
dv/tb_sliding_window_max_spread_top.sv
